/* rtl/core/hcbd_pkg.sv */
// Shared types, character codes and hex decode for the chunked body decoder.
package hcbd_pkg;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_CR = 3'd1,
    PH_DATA    = 3'd2,
    PH_TRAIL   = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t       h;
    logic [7:0] t;
    h.ok  = 1'b0;
    h.val = 4'd0;
    t     = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      t     = c - CH_0;
      h.ok  = 1'b1;
      h.val = t[3:0];
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      t     = c - CH_LO_A + HEX_TEN;
      h.ok  = 1'b1;
      h.val = t[3:0];
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      t     = c - CH_UP_A + HEX_TEN;
      h.ok  = 1'b1;
      h.val = t[3:0];
    end
    return h;
  endfunction

endpackage

/* rtl/core/hcbd_byte_if.sv */
// Input channel: one body word or a restart command.
interface hcbd_byte_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] body_byte;

  modport source (output valid, output operation, output body_byte, input ready);
  modport sink   (input valid, input operation, input body_byte, output ready);
endinterface

/* rtl/core/hcbd_result_if.sv */
// Output channel: one decoded payload word or the end-of-body marker.
interface hcbd_result_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] payload_byte;

  modport source (output valid, output result_kind, output payload_byte, input ready);
  modport sink   (input valid, input result_kind, input payload_byte, output ready);
endinterface

/* rtl/core/http_chunked_body_decoder.sv */
// Chunked transfer-encoding body decoder: strips size lines, passes payload words.
//
//   channel  dir  word fields                    handshake
//   body     in   operation, body_byte           valid/ready
//   result   out  result_kind, payload_byte      valid/ready
//
// One word per cycle unless stalled; a result is valid in the cycle after its word.
// The parser state and the output register update in the same cycle as acceptance.
// body.ready is low only while the output register holds a result not yet taken.
// rst (synchronous) returns the parser to the size-line phase and empties the output.
module http_chunked_body_decoder #(
  parameter int SIZE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  hcbd_byte_if.sink            body,
  hcbd_result_if.source        result
);

  hcbd_pkg::phase_t        phase, phase_next;
  logic [SIZE_WIDTH-1:0]   acc, acc_next;
  logic [SIZE_WIDTH-1:0]   remaining, remaining_next;
  logic                    in_ext, in_ext_next;

  logic                    res_valid;
  logic                    res_kind;
  logic [7:0]              res_byte;

  logic                    take;
  logic                    emit;
  hcbd_pkg::kind_t         emit_kind;
  logic [7:0]              emit_byte;
  hcbd_pkg::hex_t          hex;
  logic [7:0]              c;

  assign body.ready          = !res_valid || result.ready;
  assign take                = body.valid && body.ready;
  assign c                   = body.body_byte;
  assign hex                 = hcbd_pkg::hex_decode(c);

  assign result.valid        = res_valid;
  assign result.result_kind  = res_kind;
  assign result.payload_byte = res_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= hcbd_pkg::PH_SIZE;
      acc       <= '0;
      remaining <= '0;
      in_ext    <= 1'b0;
    end else begin
      phase     <= phase_next;
      acc       <= acc_next;
      remaining <= remaining_next;
      in_ext    <= in_ext_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    remaining_next = remaining;
    in_ext_next    = in_ext;
    emit           = 1'b0;
    emit_kind      = hcbd_pkg::KIND_PAYLOAD;
    emit_byte      = 8'd0;
    if (take) begin
      if (body.operation == hcbd_pkg::OP_RESTART) begin
        phase_next     = hcbd_pkg::PH_SIZE;
        acc_next       = '0;
        remaining_next = '0;
        in_ext_next    = 1'b0;
      end else begin
        unique case (phase)
          hcbd_pkg::PH_SIZE: begin
            if (c == hcbd_pkg::CH_CR) begin
              phase_next = hcbd_pkg::PH_SIZE_CR;
            end else if (c == hcbd_pkg::CH_SEMI) begin
              in_ext_next = 1'b1;
            end else if (!in_ext && hex.ok) begin
              acc_next = {acc[SIZE_WIDTH-5:0], hex.val};
            end
          end
          hcbd_pkg::PH_SIZE_CR: begin
            if (c == hcbd_pkg::CH_LF) begin
              remaining_next = acc;
              acc_next       = '0;
              in_ext_next    = 1'b0;
              if (acc == '0) begin
                phase_next = hcbd_pkg::PH_DONE;
                emit       = 1'b1;
                emit_kind  = hcbd_pkg::KIND_END;
              end else begin
                phase_next = hcbd_pkg::PH_DATA;
              end
            end
          end
          hcbd_pkg::PH_DATA: begin
            remaining_next = remaining - SIZE_WIDTH'(1);
            if (remaining == SIZE_WIDTH'(1)) begin
              phase_next = hcbd_pkg::PH_TRAIL;
            end
            emit      = 1'b1;
            emit_kind = hcbd_pkg::KIND_PAYLOAD;
            emit_byte = c;
          end
          hcbd_pkg::PH_TRAIL: begin
            if (c == hcbd_pkg::CH_CR) begin
              phase_next = hcbd_pkg::PH_SIZE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= emit;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_kind <= emit_kind;
      res_byte <= emit_byte;
    end
  end

  // end marker never carries payload
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.result_kind == hcbd_pkg::KIND_END |-> result.payload_byte == 8'd0)
    else $error("end marker with nonzero payload");

  // data phase always has words left to pass
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == hcbd_pkg::PH_DATA |-> remaining != '0)
    else $error("data phase with zero remaining count");

  // restart clears the parser
  a_restart: assert property (@(posedge clk) disable iff (rst)
    take && body.operation == hcbd_pkg::OP_RESTART |=>
      phase == hcbd_pkg::PH_SIZE && acc == '0 && remaining == '0 && !in_ext)
    else $error("restart did not clear parser state");

  // nothing comes out after the body has ended
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    take && body.operation == hcbd_pkg::OP_BYTE && phase == hcbd_pkg::PH_DONE |=> !result.valid)
    else $error("result produced after end of body");

endmodule
